@@ hw/rtl/fwcbk_pkg.sv @@
// Shared types and codes for the keyed-removal FIFO.
// Used by fwcbk_obuf and fifo_with_cancel_by_key; no dependencies.
package fwcbk_pkg;

  localparam int KEY_W = 32;
  localparam int CMD_W = 3;
  localparam int STS_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

  localparam logic [STS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [STS_W-1:0]        status;
    logic signed [KEY_W-1:0] key;
    logic                    last;
  } res_t;

endpackage

@@ hw/rtl/fwcbk_obuf.sv @@
// Result output register: holds one result beat until the consumer takes it.
// Depends on fwcbk_pkg (res_t).
module fwcbk_obuf
  import fwcbk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  res_t                    d,
  output logic                    free,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STS_W-1:0]        out_status,
  output logic signed [KEY_W-1:0] out_key_out,
  output logic                    out_last
);

  logic valid_r;
  res_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= d;
    end
  end

  assign free        = !valid_r || !out_stall;
  assign out_valid   = valid_r;
  assign out_status  = data_r.status;
  assign out_key_out = data_r.key;
  assign out_last    = data_r.last;

endmodule

@@ hw/rtl/fifo_with_cancel_by_key.sv @@
// Bounded FIFO of 32-bit keys with push, pop, peek, cancel-by-key and list.
// Depends on fwcbk_pkg and fwcbk_obuf.
// Entries live in one circular memory (one write and one registered read
// port). A command is taken only while the controller is idle and the
// result register can accept a beat. Push is handled entirely in the idle
// state; pop and peek wait for the registered memory read. Cancel reads one
// entry per cycle up to the match (or through every entry with no match),
// then moves each later entry up one slot, one per cycle, and then emits
// the result. List emits one beat per cycle while the result register is
// free, after the first read. Output stall slows every command. Error
// results come straight from idle; unused command codes produce no result.
module fifo_with_cancel_by_key
  import fwcbk_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STS_W-1:0]        out_status,
  output logic signed [KEY_W-1:0] out_key_out,
  output logic                    out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FRONT = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_LIST  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] head, logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rdata_r;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             pop_r, pop_nxt;
  logic [STS_W-1:0] res_sts_r, res_sts_nxt;

  logic             we, re;
  logic [AW-1:0]    wa, ra;
  logic [KEY_W-1:0] wd;
  logic             ob_load, ob_free;
  res_t             ob_d;
  logic             acc;
  logic [CW-1:0]    idx_inc, idx_inc2;

  assign in_stall = !((state_r == S_IDLE) && ob_free);
  assign acc      = in_valid && !in_stall;
  assign idx_inc  = idx_r + CW'(1);
  assign idx_inc2 = idx_r + CW'(2);

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    pop_nxt     = pop_r;
    res_sts_nxt = res_sts_r;
    we          = 1'b0;
    wa          = '0;
    wd          = rdata_r;
    re          = 1'b0;
    ra          = head_r;
    ob_load     = 1'b0;
    ob_d        = '{status: ST_OK, key: '0, last: 1'b1};
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (in_cmd)
            CMD_PUSH: begin
              ob_load = 1'b1;
              if (count_r == DEPTH_C) begin
                ob_d.status = ST_FULL;
              end else begin
                we        = 1'b1;
                wa        = slot_of(head_r, count_r[AW-1:0]);
                wd        = in_key;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_POP, CMD_PEEK, CMD_CANCEL, CMD_LIST: begin
              if (count_r == '0) begin
                ob_load     = 1'b1;
                ob_d.status = ST_EMPTY;
              end else begin
                re      = 1'b1;
                idx_nxt = '0;
                key_nxt = in_key;
                pop_nxt = (in_cmd == CMD_POP);
                if (in_cmd == CMD_CANCEL) begin
                  state_nxt = S_SRCH;
                end else if (in_cmd == CMD_LIST) begin
                  state_nxt = S_LIST;
                end else begin
                  state_nxt = S_FRONT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FRONT: begin
        if (ob_free) begin
          ob_load  = 1'b1;
          ob_d.key = rdata_r;
          if (pop_r) begin
            head_nxt  = slot_of(head_r, AW'(1));
            count_nxt = count_r - CW'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_SRCH: begin
        if (rdata_r == key_r) begin
          if (idx_inc < count_r) begin
            re        = 1'b1;
            ra        = slot_of(head_r, idx_inc[AW-1:0]);
            state_nxt = S_SHIFT;
          end else begin
            count_nxt   = count_r - CW'(1);
            res_sts_nxt = ST_OK;
            state_nxt   = S_EMIT;
          end
        end else if (idx_inc == count_r) begin
          res_sts_nxt = ST_NOTFOUND;
          state_nxt   = S_EMIT;
        end else begin
          re      = 1'b1;
          ra      = slot_of(head_r, idx_inc[AW-1:0]);
          idx_nxt = idx_inc;
        end
      end
      S_SHIFT: begin
        we      = 1'b1;
        wa      = slot_of(head_r, idx_r[AW-1:0]);
        wd      = rdata_r;
        idx_nxt = idx_inc;
        if (idx_inc2 < count_r) begin
          re = 1'b1;
          ra = slot_of(head_r, idx_inc2[AW-1:0]);
        end else begin
          count_nxt   = count_r - CW'(1);
          res_sts_nxt = ST_OK;
          state_nxt   = S_EMIT;
        end
      end
      S_LIST: begin
        if (ob_free) begin
          ob_load   = 1'b1;
          ob_d.key  = rdata_r;
          ob_d.last = (idx_inc == count_r);
          if (idx_inc == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            re      = 1'b1;
            ra      = slot_of(head_r, idx_inc[AW-1:0]);
            idx_nxt = idx_inc;
          end
        end
      end
      S_EMIT: begin
        if (ob_free) begin
          ob_load     = 1'b1;
          ob_d.status = res_sts_r;
          ob_d.key    = (res_sts_r == ST_OK) ? key_r : '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    pop_r     <= pop_nxt;
    res_sts_r <= res_sts_nxt;
  end

  fwcbk_obuf u_obuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (ob_load),
    .d           (ob_d),
    .free        (ob_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_key_out (out_key_out),
    .out_last    (out_last)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for fifo_with_cancel_by_key: directed corner cases, then random traffic.
// It predicts every result beat from its own queue model and checks the beats in order.
// Depends on fwcbk_pkg and the fifo_with_cancel_by_key RTL.
module testbench
  import fwcbk_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_ITEMS = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ALL_ONES = {CMD_W{1'b1}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [CMD_W-1:0]        in_cmd;
  logic signed [KEY_W-1:0] in_key;
  logic                    out_valid;
  logic                    out_stall;
  logic [STS_W-1:0]        out_status;
  logic signed [KEY_W-1:0] out_key_out;
  logic                    out_last;

  logic signed [KEY_W-1:0] queued_keys[$];
  res_t                    pending_results[$];
  int                      error_count;
  int                      cycle_count;
  int                      stall_left;
  bit                      calm;

  fifo_with_cancel_by_key #(.DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_key_out(out_key_out),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = ~clk;
  end

  // mostly short idle stretches, a few long ones; none while calm
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic expect_beat(input logic [STS_W-1:0] status,
                             input logic signed [KEY_W-1:0] key,
                             input logic last);
    res_t beat;
    beat.status = status;
    beat.key    = key;
    beat.last   = last;
    pending_results.push_back(beat);
  endtask

  // updates the queue model and queues the beats this command should produce
  task automatic apply_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [KEY_W-1:0] key);
    int hit;
    hit = -1;
    case (cmd)
      CMD_PUSH: begin
        if (queued_keys.size() >= DEPTH) begin
          expect_beat(ST_FULL, '0, 1'b1);
        end else begin
          queued_keys.push_back(key);
          expect_beat(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (queued_keys.size() == 0) begin
          expect_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          expect_beat(ST_OK, queued_keys[0], 1'b1);
          if (cmd == CMD_POP) void'(queued_keys.pop_front());
        end
      end
      CMD_CANCEL: begin
        if (queued_keys.size() == 0) begin
          expect_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < queued_keys.size(); i++) begin
            if (hit < 0 && queued_keys[i] == key) hit = i;
          end
          if (hit < 0) begin
            expect_beat(ST_NOTFOUND, '0, 1'b1);
          end else begin
            queued_keys.delete(hit);
            expect_beat(ST_OK, key, 1'b1);
          end
        end
      end
      CMD_LIST: begin
        if (queued_keys.size() == 0) begin
          expect_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < queued_keys.size(); i++) begin
            expect_beat(ST_OK, queued_keys[i], i == queued_keys.size() - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  // valid stays high from one beat to the next when there is no gap
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] key);
    int gap;
    gap = pick_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    do @(posedge clk); while (in_stall);
    apply_command(cmd, key);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && queued_keys.size() > 0)
      return queued_keys[$urandom_range(0, queued_keys.size() - 1)];
    if (r < 7) return $signed($urandom_range(0, 5)) - 2;
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input bit fill_bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)
      return CMD_W'(CMD_UNUSED_LO + $urandom_range(0, CMD_ALL_ONES - CMD_UNUSED_LO));
    if (fill_bias) begin
      if (r < 58) return CMD_PUSH;
      if (r < 68) return CMD_POP;
      if (r < 76) return CMD_PEEK;
      if (r < 91) return CMD_CANCEL;
      return CMD_LIST;
    end
    if (r < 22) return CMD_PUSH;
    if (r < 57) return CMD_POP;
    if (r < 67) return CMD_PEEK;
    if (r < 88) return CMD_CANCEL;
    return CMD_LIST;
  endfunction

  task automatic test_empty_queue();
    send_item(CMD_POP, $urandom);
    send_item(CMD_PEEK, $urandom);
    send_item(CMD_CANCEL, '0);
    send_item(CMD_LIST, $urandom);
    for (int c = CMD_UNUSED_LO; c <= CMD_ALL_ONES; c++) send_item(CMD_W'(c), $urandom);
  endtask

  // fills the queue with extreme and duplicate keys, then overfills it
  task automatic test_fill_to_full();
    logic signed [KEY_W-1:0] key;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       key = KEY_MIN;
        1:       key = KEY_MAX;
        2:       key = '0;
        3, 10:   key = '1;
        4:       key = 32'h5555_5555;
        5:       key = 32'hAAAA_AAAA;
        default: key = $urandom;
      endcase
      send_item(CMD_PUSH, key);
    end
    send_item(CMD_PUSH, KEY_MAX);
    send_item(CMD_LIST, '0);
  endtask

  task automatic test_cancel_positions();
    send_item(CMD_CANCEL, '1);
    send_item(CMD_CANCEL, KEY_MIN);
    send_item(CMD_CANCEL, queued_keys[queued_keys.size() - 1]);
    send_item(CMD_CANCEL, 32'h0000_3039);
    send_item(CMD_LIST, '0);
  endtask

  task automatic test_pause_until_drained();
    repeat (6) send_item(CMD_PUSH, pick_key());
    send_item(CMD_LIST, '0);
    wait_drained();
    send_item(CMD_PEEK, '0);
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [CMD_W-1:0] cmd;
    int sent;
    bit fill_bias;
    sent = 0;
    fill_bias = 1'b0;
    while (sent < n_items) begin
      calm = ($urandom_range(0, 3) == 0);
      fill_bias = ~fill_bias;
      repeat ($urandom_range(20, 60)) begin
        cmd = pick_cmd(fill_bias);
        send_item(cmd, pick_key());
        if (cmd <= CMD_LIST) sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_len();
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat status %0d key %0h last %0b",
                 $time, out_status, out_key_out, out_last);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_key_out !== want.key) begin
          $display("%0t: key_out expected %0h actual %0h", $time, want.key, out_key_out);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_cmd      = CMD_PUSH;
    in_key      = '0;
    out_stall   = 1'b0;
    error_count = 0;
    cycle_count = 0;
    stall_left  = 0;
    calm        = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_to_full();
    test_cancel_positions();
    test_pause_until_drained();
    test_random_traffic(RANDOM_ITEMS);

    wait_drained();
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ fifo_with_cancel_by_key.f @@
hw/rtl/fwcbk_pkg.sv
hw/rtl/fwcbk_obuf.sv
hw/rtl/fifo_with_cancel_by_key.sv
bench/testbench.sv
